### design/cbs_pkg.sv
// shared constants and types for the cubic bezier segment sampler
package cbs_pkg;

  localparam int STEPS      = 50;
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int FIX_W      = COORD_BITS + FRAC_BITS;

  // sample counter and remainder accumulator for exact t = floor(k * 2^16 / STEPS)
  localparam int K_W    = $clog2(STEPS);
  localparam int REM_W  = $clog2(STEPS) + 1;
  localparam int T_STEP = (1 << FRAC_BITS) / STEPS;
  localparam int T_REM  = (1 << FRAC_BITS) % STEPS;

  // control-point queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // pipeline depth of the back end: three lerp levels, two stages each
  localparam int PIPE_DEPTH = 6;
  localparam int T_DEPTH    = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FIX_W-1:0]      fix_t;
  typedef logic [FRAC_BITS-1:0]  tq_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } points_t;

  typedef struct packed {
    logic    valid;
    points_t pts;
  } head_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } smp_ctl_t;

endpackage

### design/cbs_front.sv
// front end: accepts control-point words into a short queue
module cbs_front import cbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t p0_x,
  input  coord_t p0_y,
  input  coord_t p1_x,
  input  coord_t p1_y,
  input  coord_t p2_x,
  input  coord_t p2_y,
  input  coord_t p3_x,
  input  coord_t p3_y,
  output head_t  head,
  input  logic   pop
);

  points_t             q [QDEPTH];
  points_t             pts_in;
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;

  always_comb begin
    pts_in.x = {p3_x, p2_x, p1_x, p0_x};
    pts_in.y = {p3_y, p2_y, p1_y, p0_y};
  end

  assign head.valid = (count != '0);
  assign head.pts   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= pts_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/cbs_lerp.sv
// one fixed-point lerp a + (b - a) * t, product stage then add stage
module cbs_lerp import cbs_pkg::*; (
  input  logic clk,
  input  logic en,
  input  tq_t  t,
  input  fix_t a,
  input  fix_t b,
  output fix_t y
);

  logic signed [FIX_W:0]             diff;
  logic signed [FRAC_BITS:0]         t_s;
  logic signed [FIX_W+FRAC_BITS+1:0] prod_next;
  logic signed [FIX_W+FRAC_BITS+1:0] prod;
  fix_t                              base;
  logic signed [FIX_W+1:0]           sum;

  always_comb begin
    diff      = $signed({1'b0, b}) - $signed({1'b0, a});
    t_s       = $signed({1'b0, t});
    prod_next = diff * t_s;
    // arithmetic shift keeps floor for negative differences
    sum       = $signed({2'b00, base}) + $signed(prod[FIX_W+FRAC_BITS+1:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      base <= a;
      y    <= sum[FIX_W-1:0];
    end
  end

endmodule

### design/cbs_back.sv
// back end: sample sequencer, de casteljau lerp pipeline and output register
module cbs_back import cbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  head_t  head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t from_x,
  output coord_t from_y,
  output coord_t to_x,
  output coord_t to_y,
  output logic   draw,
  output logic   last
);

  logic              adv;
  logic              issue;
  logic              k_end;
  logic [K_W-1:0]    k;
  tq_t               t_cur;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sum;
  smp_ctl_t          ctl_pipe [PIPE_DEPTH];
  tq_t               t_pipe [T_DEPTH];
  fix_t              ctrl [2][4];
  fix_t              m [2][3];
  fix_t              qv [2][2];
  fix_t              r [2];
  coord_t            cur_x;
  coord_t            cur_y;
  coord_t            prev_x;
  coord_t            prev_y;
  coord_t            fx;
  coord_t            fy;

  // whole pipeline moves when the output register can take a word
  assign adv   = !out_valid || out_ready;
  assign issue = adv && head.valid;
  assign k_end = (k == K_W'(STEPS - 1));
  assign pop   = issue && k_end;

  assign rem_sum = rem + REM_W'(T_REM);

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      t_cur <= '0;
      rem   <= '0;
    end else if (issue) begin
      if (k_end) begin
        k     <= '0;
        t_cur <= '0;
        rem   <= '0;
      end else begin
        k <= k + 1'b1;
        if (rem_sum >= REM_W'(STEPS)) begin
          rem   <= rem_sum - REM_W'(STEPS);
          t_cur <= t_cur + FRAC_BITS'(T_STEP + 1);
        end else begin
          rem   <= rem_sum;
          t_cur <= t_cur + FRAC_BITS'(T_STEP);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ctrl[0][i] = {head.pts.x[i], {FRAC_BITS{1'b0}}};
      ctrl[1][i] = {head.pts.y[i], {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_coord
    for (genvar i = 0; i < 3; i++) begin : g_l1
      cbs_lerp u_l1 (
        .clk (clk),
        .en  (adv),
        .t   (t_cur),
        .a   (ctrl[c][i]),
        .b   (ctrl[c][i+1]),
        .y   (m[c][i])
      );
    end
    for (genvar i = 0; i < 2; i++) begin : g_l2
      cbs_lerp u_l2 (
        .clk (clk),
        .en  (adv),
        .t   (t_pipe[1]),
        .a   (m[c][i]),
        .b   (m[c][i+1]),
        .y   (qv[c][i])
      );
    end
    cbs_lerp u_l3 (
      .clk (clk),
      .en  (adv),
      .t   (t_pipe[3]),
      .a   (qv[c][0]),
      .b   (qv[c][1]),
      .y   (r[c])
    );
  end

  // t and sample flags travel beside the lerp stages
  always_ff @(posedge clk) begin
    if (adv) begin
      t_pipe[0] <= t_cur;
      for (int i = 1; i < T_DEPTH; i++) begin
        t_pipe[i] <= t_pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        ctl_pipe[i] <= '0;
      end
    end else if (adv) begin
      ctl_pipe[0].valid <= issue;
      ctl_pipe[0].first <= (k == '0);
      ctl_pipe[0].last  <= k_end;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        ctl_pipe[i] <= ctl_pipe[i-1];
      end
    end
  end

  always_comb begin
    cur_x = r[0][FIX_W-1:FRAC_BITS];
    cur_y = r[1][FIX_W-1:FRAC_BITS];
    fx    = ctl_pipe[PIPE_DEPTH-1].first ? cur_x : prev_x;
    fy    = ctl_pipe[PIPE_DEPTH-1].first ? cur_y : prev_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_pipe[PIPE_DEPTH-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_pipe[PIPE_DEPTH-1].valid) begin
      from_x <= fx;
      from_y <= fy;
      to_x   <= cur_x;
      to_y   <= cur_y;
      draw   <= (fx != cur_x) || (fy != cur_y);
      last   <= ctl_pipe[PIPE_DEPTH-1].last;
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

endmodule

### design/cubic_bezier_segment_sampler_unit.sv
// top level of the cubic bezier segment sampler
//
// Each input word carries four control points; the block evaluates the cubic
// by de Casteljau interpolation at t = k/STEPS (k = 0 .. STEPS-1, t truncated to
// Q0.16) and sends one output word per sample: a segment from the previous
// sample's pixel to the current one, a draw flag (clear on the first sample
// and when both ends fall on the same pixel) and a last flag on the final
// sample. Throughput is one sample per cycle while a curve is queued and the
// output is not stalled; the sample sequencer in the back end issues one t
// value per cycle into the lerp pipeline, whose last stage feeds the output
// register. A two-word control-point queue sits in front, so new items are
// taken while the previous one is still being sampled, and back pressure on
// the output stalls only the back end.
module cubic_bezier_segment_sampler_unit import cbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t p0_x,
  input  coord_t p0_y,
  input  coord_t p1_x,
  input  coord_t p1_y,
  input  coord_t p2_x,
  input  coord_t p2_y,
  input  coord_t p3_x,
  input  coord_t p3_y,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t from_x,
  output coord_t from_y,
  output coord_t to_x,
  output coord_t to_y,
  output logic   draw,
  output logic   last
);

  head_t head;
  logic  pop;

  // front: control-point queue
  cbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .p0_x     (p0_x),
    .p0_y     (p0_y),
    .p1_x     (p1_x),
    .p1_y     (p1_y),
    .p2_x     (p2_x),
    .p2_y     (p2_y),
    .p3_x     (p3_x),
    .p3_y     (p3_y),
    .head     (head),
    .pop      (pop)
  );

  // back: sequencer, lerp pipeline, output word register
  cbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .draw      (draw),
    .last      (last)
  );

endmodule

### sim/cubic_bezier_segment_sampler_unit_test.sv
// testbench for the cubic bezier segment sampler: random and directed curves vs a fixed-point model
module cubic_bezier_segment_sampler_unit_test import cbs_pkg::*;;

  // one input word: four control points, index 0 is p0
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } ctrl_pts_t;

  // one output word as the block should send it
  typedef struct {
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    logic   draw;
    logic   last;
  } segment_t;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 400;   // receiver hold-off, well past queue depth
  localparam int unsigned DRAIN_WAIT  = 20;    // pipeline latency plus margin

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t p0_x = '0, p0_y = '0, p1_x = '0, p1_y = '0;
  coord_t p2_x = '0, p2_y = '0, p3_x = '0, p3_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t from_x, from_y, to_x, to_y;
  logic   draw, last;

  ctrl_pts_t   pending_curves[$];   // curves still to be offered by the driver
  segment_t    due_segments[$];     // segments predicted but not yet seen
  ctrl_pts_t   next_curve;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned long_left = 0;
  bit          idle_on = 1'b0;      // random idling on both sides
  bit          want_long_hold = 1'b0;
  bit          long_hold_done = 1'b0;

  cubic_bezier_segment_sampler_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .p0_x      (p0_x),
    .p0_y      (p0_y),
    .p1_x      (p1_x),
    .p1_y      (p1_y),
    .p2_x      (p2_x),
    .p2_y      (p2_y),
    .p3_x      (p3_x),
    .p3_y      (p3_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .draw      (draw),
    .last      (last)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point curve prediction
  // ---------------------------------------------------------------------------

  // one interpolation step in Q.16, exact before the truncating shift
  function automatic logic [63:0] lerp_fix(logic [63:0] a, logic [63:0] b, logic [63:0] t);
    return (a * ((64'd1 << FRAC_BITS) - t) + b * t) >> FRAC_BITS;
  endfunction

  // de casteljau evaluation of one axis at sample k, result in Q10.16
  function automatic fix_t curve_at(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                                    int unsigned k);
    logic [63:0] t, a0, a1, a2, a3, m1, m2, m3, qa, qb;
    t  = (64'(k) << FRAC_BITS) / STEPS;
    a0 = 64'(c0) << FRAC_BITS;
    a1 = 64'(c1) << FRAC_BITS;
    a2 = 64'(c2) << FRAC_BITS;
    a3 = 64'(c3) << FRAC_BITS;
    m1 = lerp_fix(a0, a1, t);
    m2 = lerp_fix(a1, a2, t);
    m3 = lerp_fix(a2, a3, t);
    qa = lerp_fix(m1, m2, t);
    qb = lerp_fix(m2, m3, t);
    return fix_t'(lerp_fix(qa, qb, t));
  endfunction

  // queue up every segment that one accepted curve must produce
  task automatic predict_segments(ctrl_pts_t c);
    fix_t     cur_x, cur_y, prv_x, prv_y;
    segment_t seg;
    prv_x = '0;
    prv_y = '0;
    for (int unsigned k = 0; k < STEPS; k++) begin
      cur_x = curve_at(c.x[0], c.x[1], c.x[2], c.x[3], k);
      cur_y = curve_at(c.y[0], c.y[1], c.y[2], c.y[3], k);
      // first sample starts where it ends, so nothing gets drawn
      if (k == 0) begin
        prv_x = cur_x;
        prv_y = cur_y;
      end
      seg.from_x = coord_t'(prv_x >> FRAC_BITS);
      seg.from_y = coord_t'(prv_y >> FRAC_BITS);
      seg.to_x   = coord_t'(cur_x >> FRAC_BITS);
      seg.to_y   = coord_t'(cur_y >> FRAC_BITS);
      seg.draw   = (seg.from_x != seg.to_x) || (seg.from_y != seg.to_y);
      seg.last   = (k == STEPS - 1);
      due_segments.push_back(seg);
      prv_x = cur_x;
      prv_y = cur_y;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ctrl_pts_t curve_of(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                         coord_t x2, coord_t y2, coord_t x3, coord_t y3);
    ctrl_pts_t c;
    c.x[0] = x0; c.y[0] = y0;
    c.x[1] = x1; c.y[1] = y1;
    c.x[2] = x2; c.y[2] = y2;
    c.x[3] = x3; c.y[3] = y3;
    return c;
  endfunction

  // mostly free curves, some packed into a few pixels (lots of skipped
  // segments), some pinned to the corners of the coordinate range
  function automatic ctrl_pts_t random_curve();
    ctrl_pts_t   c;
    int unsigned style;
    coord_t      bx, by;
    style = $urandom_range(0, 9);
    bx    = coord_t'($urandom_range(0, 1019));
    by    = coord_t'($urandom_range(0, 1019));
    for (int i = 0; i < 4; i++) begin
      if (style < 6) begin
        c.x[i] = coord_t'($urandom);
        c.y[i] = coord_t'($urandom);
      end else if (style < 8) begin
        c.x[i] = bx + coord_t'($urandom_range(0, 3));
        c.y[i] = by + coord_t'($urandom_range(0, 3));
      end else begin
        case ($urandom_range(0, 2))
          0: c.x[i] = '0;
          1: c.x[i] = '1;
          default: c.x[i] = coord_t'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0: c.y[i] = '0;
          1: c.y[i] = '1;
          default: c.y[i] = coord_t'($urandom);
        endcase
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers queued curves, random gaps between words
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      // word on the port was taken at this edge
      if (in_valid)
        predict_segments(curve_of(p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y));
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_curves.size() != 0) begin
        next_curve = pending_curves.pop_front();
        p0_x <= next_curve.x[0];
        p0_y <= next_curve.y[0];
        p1_x <= next_curve.x[1];
        p1_y <= next_curve.y[1];
        p2_x <= next_curve.x[2];
        p2_y <= next_curve.y[2];
        p3_x <= next_curve.x[3];
        p3_y <= next_curve.y[3];
        in_valid <= 1'b1;
        // idle burst after this word is accepted
        if (idle_on && $urandom_range(0, 3) == 0)
          gap_left <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: checks each taken word, drives ready with stalls
  // ---------------------------------------------------------------------------

  task automatic check_segment();
    segment_t want;
    if (due_segments.size() == 0) begin
      $error("unexpected output word: from (%0d,%0d) to (%0d,%0d)",
             from_x, from_y, to_x, to_y);
      fail_count++;
    end else begin
      want = due_segments.pop_front();
      if (from_x !== want.from_x) begin
        $error("from_x: expected %0d, got %0d", want.from_x, from_x);
        fail_count++;
      end
      if (from_y !== want.from_y) begin
        $error("from_y: expected %0d, got %0d", want.from_y, from_y);
        fail_count++;
      end
      if (to_x !== want.to_x) begin
        $error("to_x: expected %0d, got %0d", want.to_x, to_x);
        fail_count++;
      end
      if (to_y !== want.to_y) begin
        $error("to_y: expected %0d, got %0d", want.to_y, to_y);
        fail_count++;
      end
      if (draw !== want.draw) begin
        $error("draw: expected %0d, got %0d", want.draw, draw);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      long_left  <= 0;
    end else begin
      if (out_valid && out_ready)
        check_segment();
      if (long_left != 0) begin
        // long hold-off in progress, counted here
        long_left <= long_left - 1;
        out_ready <= (long_left == 1);
        if (long_left == 1)
          long_hold_done <= 1'b1;
      end else if (want_long_hold && !long_hold_done) begin
        long_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 13);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cubic_bezier_segment_sampler_unit_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  // hold the sender until every queued curve is taken and every segment seen
  task automatic drain();
    while (pending_curves.size() != 0 || in_valid || due_segments.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed curves, with idling
    idle_on = 1'b1;
    // corners (0,0) and (1023,1023) of the range, degenerate single points
    pending_curves.push_back(curve_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending_curves.push_back(curve_of(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
    // straight lines across the full span: one along each axis, a diagonal both ways
    pending_curves.push_back(curve_of(0, 0, 341, 0, 682, 0, 1023, 0));
    pending_curves.push_back(curve_of(0, 1023, 0, 682, 0, 341, 0, 0));
    pending_curves.push_back(curve_of(0, 0, 0, 0, 1023, 1023, 1023, 1023));
    pending_curves.push_back(curve_of(1023, 1023, 1023, 1023, 0, 0, 0, 0));
    // loops and sharp turns hitting the edges
    pending_curves.push_back(curve_of(0, 0, 1023, 1023, 0, 1023, 1023, 0));
    pending_curves.push_back(curve_of(1023, 0, 0, 1023, 1023, 1023, 0, 0));
    pending_curves.push_back(curve_of(0, 1023, 1023, 0, 1023, 0, 0, 1023));
    // tiny motion: most segments land on the same pixel
    pending_curves.push_back(curve_of(5, 7, 5, 7, 6, 7, 6, 8));
    pending_curves.push_back(curve_of(512, 512, 513, 511, 511, 513, 512, 512));
    // walking single bits through every field
    for (int b = 0; b < 10; b++)
      pending_curves.push_back(curve_of(coord_t'(1 << b), coord_t'(1 << b),
                                        coord_t'(1 << b), coord_t'(1 << b),
                                        coord_t'(1 << b), coord_t'(1 << b),
                                        coord_t'(1 << b), coord_t'(1 << b)));
    // sender waits for everything to come back
    drain();

    // receiver holds off while the sender keeps offering, input must back up
    idle_on = 1'b0;
    want_long_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      pending_curves.push_back(random_curve());
    while (!long_hold_done)
      @(posedge clk);
    drain();

    // random chunks, idling switched on or off per chunk
    for (int chunk = 0; chunk < 7; chunk++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 40; i++)
        pending_curves.push_back(random_curve());
      while (pending_curves.size() != 0)
        @(posedge clk);
    end

    // closing stretch at full rate
    idle_on = 1'b0;
    for (int i = 0; i < 60; i++)
      pending_curves.push_back(random_curve());

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("cubic_bezier_segment_sampler_unit_test: PASS");
    else
      $display("cubic_bezier_segment_sampler_unit_test: FAIL");
    $finish;
  end

endmodule
